// ===== src/acs_pkg.sv =====
`default_nettype none
package acs_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned MaxMarks = 8;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] shaped_char;
    logic               line_done;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] iso;
    logic [15:0] fin;
    logic [15:0] med;
    logic [15:0] ini;
  } forms_t;

  // command from controller to datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,      // capture input item and classify it
    CMD_EMIT_BASE, // resolved base to output
    CMD_EMIT_MARK, // buffered mark to output
    CMD_EMIT_IN,   // incoming mark to output
    CMD_FINISH,    // update pending state after item
    CMD_CLEAR      // end of line, drop all pending state
  } cmd_t;

  typedef struct packed {
    logic is_mark;
    logic eol;
    logic pend;
    logic buf_full;
    logic more_marks; // a buffered mark remains after the one being read
    logic any_marks;
  } stat_t;

  function automatic logic is_mark_cp(input logic [CpWidth-1:0] cp);
    logic r;
    r = 1'b0;
    case (cp)
      21'h064b, 21'h064c, 21'h064d, 21'h064e, 21'h064f, 21'h0650, 21'h0670,
      21'h06d7, 21'h06d8, 21'h06d9, 21'h06da, 21'h06db, 21'h06dc, 21'h06df,
      21'h06e0, 21'h06e1, 21'h06e2, 21'h06e3, 21'h06e4, 21'h06e7, 21'h06e8,
      21'h06ea, 21'h06eb, 21'h06ec, 21'h06ed: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic forms_t f4(input logic [15:0] i, input logic [15:0] f,
                                input logic [15:0] m, input logic [15:0] n);
    forms_t r;
    r.iso = i; r.fin = f; r.med = m; r.ini = n;
    return r;
  endfunction

  function automatic forms_t form_lookup(input logic [CpWidth-1:0] cp);
    forms_t r;
    logic [15:0] c;
    c = cp[15:0];
    r = '0;
    if (cp[CpWidth-1:16] == '0) begin
      case (c)
        16'h0621: r = f4(16'hfe80, 0, 0, 0);
        16'h0622: r = f4(16'hfe81, 16'hfe82, 0, 0);
        16'h0623: r = f4(16'hfe83, 16'hfe84, 0, 0);
        16'h0624: r = f4(16'hfe85, 16'hfe86, 0, 0);
        16'h0625: r = f4(16'hfe87, 16'hfe88, 0, 0);
        16'h0626: r = f4(16'hfe89, 16'hfe8a, 16'hfe8c, 16'hfe8b);
        16'h0627: r = f4(16'hfe8d, 16'hfe8e, 0, 0);
        16'h0628: r = f4(16'hfe8f, 16'hfe90, 16'hfe92, 16'hfe91);
        16'h0629: r = f4(16'hfe93, 16'hfe94, 0, 0);
        16'h062a: r = f4(16'hfe95, 16'hfe96, 16'hfe98, 16'hfe97);
        16'h062b: r = f4(16'hfe99, 16'hfe9a, 16'hfe9c, 16'hfe9b);
        16'h062c: r = f4(16'hfe9d, 16'hfe9e, 16'hfea0, 16'hfe9f);
        16'h062d: r = f4(16'hfea1, 16'hfea2, 16'hfea4, 16'hfea3);
        16'h062e: r = f4(16'hfea5, 16'hfea6, 16'hfea8, 16'hfea7);
        16'h062f: r = f4(16'hfea9, 16'hfeaa, 0, 0);
        16'h0630: r = f4(16'hfeab, 16'hfeac, 0, 0);
        16'h0631: r = f4(16'hfead, 16'hfeae, 0, 0);
        16'h0632: r = f4(16'hfeaf, 16'hfeb0, 0, 0);
        16'h0633: r = f4(16'hfeb1, 16'hfeb2, 16'hfeb4, 16'hfeb3);
        16'h0634: r = f4(16'hfeb5, 16'hfeb6, 16'hfeb8, 16'hfeb7);
        16'h0635: r = f4(16'hfeb9, 16'hfeba, 16'hfebc, 16'hfebb);
        16'h0636: r = f4(16'hfebd, 16'hfebe, 16'hfec0, 16'hfebf);
        16'h0637: r = f4(16'hfec1, 16'hfec2, 16'hfec4, 16'hfec3);
        16'h0638: r = f4(16'hfec5, 16'hfec6, 16'hfec8, 16'hfec7);
        16'h0639: r = f4(16'hfec9, 16'hfeca, 16'hfecc, 16'hfecb);
        16'h063a: r = f4(16'hfecd, 16'hfece, 16'hfed0, 16'hfecf);
        16'h0641: r = f4(16'hfed1, 16'hfed2, 16'hfed4, 16'hfed3);
        16'h0642: r = f4(16'hfed5, 16'hfed6, 16'hfed8, 16'hfed7);
        16'h0643: r = f4(16'hfed9, 16'hfeda, 16'hfedc, 16'hfedb);
        16'h0644: r = f4(16'hfedd, 16'hfede, 16'hfee0, 16'hfedf);
        16'h0645: r = f4(16'hfee1, 16'hfee2, 16'hfee4, 16'hfee3);
        16'h0646: r = f4(16'hfee5, 16'hfee6, 16'hfee8, 16'hfee7);
        16'h0647: r = f4(16'hfee9, 16'hfeea, 16'hfeec, 16'hfeeb);
        16'h0648: r = f4(16'hfeed, 16'hfeee, 0, 0);
        16'h0649: r = f4(16'hfeef, 16'hfef0, 0, 0);
        16'h064a: r = f4(16'hfef1, 16'hfef2, 16'hfef4, 16'hfef3);
        16'h0671: r = f4(16'hfb50, 0, 0, 0);
        16'h0674: r = f4(16'h0674, 0, 0, 0);
        16'h0677: r = f4(16'hfbdd, 16'h0677, 0, 0);
        16'h0679: r = f4(16'hfb66, 16'hfb67, 16'hfb69, 16'hfb68);
        16'h067a: r = f4(16'hfb5e, 16'hfb5f, 16'hfb61, 16'hfb60);
        16'h067b: r = f4(16'hfb52, 16'hfb53, 16'hfb55, 16'hfb54);
        16'h067e: r = f4(16'hfb56, 16'hfb57, 16'hfb59, 16'hfb58);
        16'h067f: r = f4(16'hfb62, 16'hfb63, 16'hfb65, 16'hfb64);
        16'h0680: r = f4(16'hfb5a, 16'hfb5b, 16'hfb5d, 16'hfb5c);
        16'h0683: r = f4(16'hfb76, 16'hfb77, 16'hfb79, 16'hfb78);
        16'h0684: r = f4(16'hfb72, 16'hfb73, 16'hfb75, 16'hfb74);
        16'h0686: r = f4(16'hfb7a, 16'hfb7b, 16'hfb7d, 16'hfb7c);
        16'h0687: r = f4(16'hfb7e, 16'hfb7f, 16'hfb81, 16'hfb80);
        16'h0688: r = f4(16'hfb88, 16'hfb89, 0, 0);
        16'h068c: r = f4(16'hfb84, 16'hfb85, 0, 0);
        16'h068d: r = f4(16'hfb82, 16'hfb83, 0, 0);
        16'h068e: r = f4(16'hfb86, 16'hfb87, 0, 0);
        16'h0691: r = f4(16'hfb8c, 16'hfb8d, 0, 0);
        16'h0696: r = f4(16'h0695, 16'h0696, 0, 0);
        16'h0698: r = f4(16'hfb8a, 16'hfb8b, 0, 0);
        16'h06a4: r = f4(16'hfb6a, 16'hfb6b, 16'hfb6d, 16'hfb6c);
        16'h06a6: r = f4(16'hfb6e, 16'hfb6f, 16'hfb71, 16'hfb70);
        16'h06a9: r = f4(16'hfb8e, 16'hfb8f, 16'hfb91, 16'hfb90);
        16'h06ad: r = f4(16'hfbd3, 16'hfbd4, 16'hfbd6, 16'hfbd5);
        16'h06af: r = f4(16'hfb92, 16'hfb93, 16'hfb95, 16'hfb94);
        16'h06b1: r = f4(16'hfb9a, 16'hfb9b, 16'hfb9d, 16'hfb9c);
        16'h06b3: r = f4(16'hfb96, 16'hfb97, 16'hfb99, 16'hfb98);
        16'h06ba: r = f4(16'hfb9e, 16'hfb9f, 16'h06ba, 16'h06ba);
        16'h06bb: r = f4(16'hfba0, 16'hfba1, 16'hfba3, 16'hfba2);
        16'h06be: r = f4(16'hfbaa, 16'hfbab, 16'hfbad, 16'hfbac);
        16'h06c0: r = f4(16'hfba4, 16'hfba5, 0, 0);
        16'h06c1: r = f4(16'hfba6, 16'hfba7, 16'hfba9, 16'hfba8);
        16'h06c5: r = f4(16'hfbe0, 16'hfbe1, 0, 0);
        16'h06c6: r = f4(16'hfbd9, 16'hfbda, 0, 0);
        16'h06c7: r = f4(16'hfbd7, 16'hfbd8, 0, 0);
        16'h06c8: r = f4(16'hfbdb, 16'hfbdc, 0, 0);
        16'h06c9: r = f4(16'hfbe2, 16'hfbe3, 0, 0);
        16'h06cb: r = f4(16'hfbde, 16'hfbdf, 0, 0);
        16'h06cc: r = f4(16'hfbfc, 16'hfbfd, 16'hfbff, 16'hfbfe);
        16'h06d0: r = f4(16'hfbe4, 16'hfbe5, 16'hfbe7, 16'hfbe6);
        16'h06d2: r = f4(16'hfbae, 16'hfbaf, 0, 0);
        16'h06d3: r = f4(16'hfbb0, 16'hfbb1, 0, 0);
        16'h06d5: r = f4(16'h06d5, 0, 0, 0);
        // letters that map to themselves in every form
        16'h0640, 16'h0678, 16'h067c, 16'h067d, 16'h0681, 16'h0682, 16'h0685,
        16'h069a, 16'h069b, 16'h069c, 16'h069d, 16'h069e, 16'h069f, 16'h06a0,
        16'h06a1, 16'h06a2, 16'h06a3, 16'h06a5, 16'h06a7, 16'h06a8, 16'h06aa,
        16'h06ab, 16'h06ac, 16'h06ae, 16'h06b0, 16'h06b2, 16'h06b4, 16'h06b5,
        16'h06b6, 16'h06b7, 16'h06bc, 16'h06bd, 16'h06ce, 16'h06d1, 16'h200d:
          r = f4(c, c, c, c);
        // letters with no medial or initial form of their own
        16'h0672, 16'h0673, 16'h0675, 16'h0676, 16'h0689, 16'h068a, 16'h068b,
        16'h068f, 16'h0690, 16'h0692, 16'h0693, 16'h0694, 16'h0695, 16'h0697,
        16'h0699, 16'h06c2, 16'h06c3, 16'h06c4, 16'h06ca, 16'h06cd:
          r = f4(c, c, 16'h0, 16'h0);
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/arabic_contextual_shaper.sv =====
`default_nettype none
// arabic contextual shaper
// in channel: one code point per transaction (code_point, end_of_line)
// out channel: shaped characters and passed-through marks, with line_done on
//   the last character of a line and last_of_run on the last one caused by
//   the transaction in
// a base letter is held until the next non-mark, end of line or a mark that
//   overflows the buffer; marks wait behind it in a small ram of MaxMarks entries
// sequencing: each transaction in is accepted, decided and finished; flushing
//   a held base emits it and then each buffered mark, a passed mark is emitted
//   on its own, and an end of line makes a second pass to flush the base it
//   leaves; a new transaction is taken only once the last one is finished;
//   the ram read and the single output register set the pace
// in_ready is high only while the sequencer waits for a new transaction
// a stalled receiver holds the output register and the sequencer waits
// synchronous reset clears the held base, join flag and mark count; ram
//   contents are never read before they are written
module arabic_contextual_shaper #(
  parameter int unsigned MaxMarks = acs_pkg::MaxMarks
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire acs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output acs_pkg::out_item_t      out_data
);
  import acs_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  last_flag;

  acs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .last_flag (last_flag)
  );

  acs_datapath #(.MaxMarks(MaxMarks)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_data),
    .last_flag (last_flag),
    .stat      (stat),
    .res       (out_data)
  );

  // no new transaction is loaded while the base is being emitted
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(cmd == CMD_EMIT_BASE))
    else $error("load during emit");
  // line_done only on last of run
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.line_done || out_data.last_of_run))
    else $error("line_done without last_of_run");
endmodule
`default_nettype wire

// ===== src/acs_ram.sv =====
`default_nettype none
module acs_ram #(
  parameter int unsigned Width = 21,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/acs_datapath.sv =====
`default_nettype none
module acs_datapath #(
  parameter int unsigned MaxMarks = acs_pkg::MaxMarks
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire acs_pkg::cmd_t      cmd,
  input  wire acs_pkg::in_item_t  in_item,
  input  wire logic               last_flag,
  output acs_pkg::stat_t          stat,
  output acs_pkg::out_item_t      res
);
  import acs_pkg::*;

  localparam int unsigned AddrW = (MaxMarks > 1) ? $clog2(MaxMarks) : 1;
  localparam int unsigned CntW  = $clog2(MaxMarks + 1);
  localparam int unsigned RamD  = (MaxMarks > 1) ? MaxMarks : 2;

  logic [CpWidth-1:0] pending_base;
  logic               pending_valid;
  logic               joins_from_left;
  logic [CntW-1:0]    mark_count;
  logic [CntW-1:0]    rd_ptr;
  logic [CpWidth-1:0] cur_cp;
  logic               cur_eol;
  logic               cur_mark;
  logic [15:0]        next_fin;
  forms_t             base_forms;
  forms_t             in_forms;

  logic               ram_we;
  logic [CpWidth-1:0] ram_rdata;
  logic [CntW-1:0]    rd_ptr_next;
  logic               nf;
  logic [CpWidth-1:0] resolved;

  assign ram_we = (cmd == CMD_FINISH) && cur_mark && pending_valid
                  && (mark_count < CntW'(MaxMarks));
  assign rd_ptr_next = (cmd == CMD_EMIT_MARK) ? rd_ptr + 1'b1 : rd_ptr;

  acs_ram #(.Width(CpWidth), .Depth(RamD)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (mark_count[AddrW-1:0]),
    .wdata (cur_cp),
    .raddr (rd_ptr_next[AddrW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_forms   = form_lookup(in_item.code_point);
  assign base_forms = form_lookup(pending_base);

  // follower final form: only a non-mark item carries one into resolution
  assign nf = (next_fin != 16'h0) && !cur_mark;

  always_comb begin
    if (joins_from_left && nf && base_forms.med != 0) begin
      resolved = CpWidth'(base_forms.med);
    end else if (nf && base_forms.ini != 0) begin
      resolved = CpWidth'(base_forms.ini);
    end else if (joins_from_left && base_forms.fin != 0) begin
      resolved = CpWidth'(base_forms.fin);
    end else if (base_forms.iso != 0) begin
      resolved = CpWidth'(base_forms.iso);
    end else begin
      resolved = pending_base;
    end
  end

  always_comb begin
    stat.is_mark    = cur_mark;
    stat.eol        = cur_eol;
    stat.pend       = pending_valid;
    stat.buf_full   = mark_count >= CntW'(MaxMarks);
    stat.any_marks  = mark_count != '0;
    stat.more_marks = (rd_ptr + 1'b1) < mark_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid   <= 1'b0;
      joins_from_left <= 1'b0;
      mark_count      <= '0;
      pending_base    <= '0;
      rd_ptr          <= '0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          cur_cp   <= in_item.code_point;
          cur_eol  <= in_item.end_of_line;
          cur_mark <= is_mark_cp(in_item.code_point);
          next_fin <= in_forms.fin;
          rd_ptr   <= '0;
        end
        CMD_EMIT_BASE: begin
          res.shaped_char <= resolved;
          res.line_done   <= last_flag && cur_eol;
          res.last_of_run <= last_flag;
          joins_from_left <= (base_forms.ini != 0) && nf;
        end
        CMD_EMIT_MARK: begin
          res.shaped_char <= ram_rdata;
          res.line_done   <= last_flag && cur_eol;
          res.last_of_run <= last_flag;
          rd_ptr          <= rd_ptr_next;
        end
        CMD_EMIT_IN: begin
          res.shaped_char <= cur_cp;
          res.line_done   <= last_flag && cur_eol;
          res.last_of_run <= last_flag;
        end
        CMD_FINISH: begin
          // at end of line the held base resolves with nothing after it
          if (cur_eol) begin
            next_fin <= '0;
          end
          if (!cur_mark) begin
            pending_valid <= 1'b1;
            pending_base  <= cur_cp;
            mark_count    <= '0;
          end else if (pending_valid) begin
            if (mark_count < CntW'(MaxMarks)) begin
              mark_count <= mark_count + 1'b1;
            end else begin
              pending_valid   <= 1'b0;
              joins_from_left <= 1'b0;
              mark_count      <= '0;
            end
          end
        end
        CMD_CLEAR: begin
          pending_valid   <= 1'b0;
          pending_base    <= '0;
          joins_from_left <= 1'b0;
          mark_count      <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/acs_ctrl.sv =====
`default_nettype none
module acs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire acs_pkg::stat_t stat,
  output acs_pkg::cmd_t       cmd,
  output logic                last_flag
);
  import acs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_BASE, S_MARK, S_IN, S_WAIT, S_FINISH
  } state_t;

  state_t state, ret;
  // base emitted for this item is flushed with nothing after it (overflow or eol)
  logic   flush_plain;
  // second pass of an item that ends a line, flushing the base it left
  logic   eol_pass;
  logic   emit;

  assign in_ready = (state == S_IDLE);
  assign emit = (cmd == CMD_EMIT_BASE) || (cmd == CMD_EMIT_MARK) || (cmd == CMD_EMIT_IN);

  always_comb begin
    cmd       = CMD_NONE;
    last_flag = 1'b0;
    case (state)
      S_IDLE:   if (in_valid) cmd = CMD_LOAD;
      S_BASE: begin
        if (!out_valid || out_ready) begin
          cmd = CMD_EMIT_BASE;
          last_flag = !stat.any_marks && (eol_pass || (!stat.is_mark && !stat.eol));
        end
      end
      S_MARK: begin
        if (!out_valid || out_ready) begin
          cmd = CMD_EMIT_MARK;
          last_flag = !stat.more_marks && (eol_pass || (!stat.is_mark && !stat.eol));
        end
      end
      S_IN: begin
        if (!out_valid || out_ready) begin
          cmd = CMD_EMIT_IN;
          last_flag = 1'b1;
        end
      end
      S_FINISH: cmd = (stat.eol && flush_plain) ? CMD_CLEAR : CMD_FINISH;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      flush_plain <= 1'b0;
      eol_pass    <= 1'b0;
      ret         <= S_FINISH;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          flush_plain <= stat.is_mark && stat.pend && stat.buf_full;
          eol_pass    <= 1'b0;
          if (stat.is_mark) begin
            if (!stat.pend) begin
              state <= S_IN;
            end else if (stat.buf_full) begin
              state <= S_BASE;
            end else begin
              state <= S_FINISH;
            end
          end else if (stat.pend) begin
            state <= S_BASE;
          end else begin
            state <= S_FINISH;
          end
        end
        S_BASE: begin
          if (!out_valid || out_ready) begin
            state <= stat.any_marks ? S_MARK : S_WAIT;
            ret   <= (flush_plain && stat.is_mark && !eol_pass) ? S_IN : S_FINISH;
          end
        end
        S_MARK: begin
          if (!out_valid || out_ready) begin
            if (!stat.more_marks) begin
              state <= S_WAIT;
            end
          end
        end
        S_IN: begin
          if (!out_valid || out_ready) begin
            state <= S_FINISH;
            ret   <= S_FINISH;
          end
        end
        S_WAIT: begin
          state <= ret;
          ret   <= S_FINISH;
        end
        S_FINISH: begin
          // end of line with a base still held: flush it as if nothing followed
          if (stat.eol && !flush_plain && (!stat.is_mark || stat.pend)) begin
            flush_plain <= 1'b1;
            eol_pass    <= 1'b1;
            state <= S_BASE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
